[rtl/core/tscs_pkg.sv]
// ----------------------------------------------------------------------------
// tscs_pkg
// Shared types and constants of the cyclic time slot scheduler.
// ----------------------------------------------------------------------------
package tscs_pkg;

  localparam int unsigned MaxSlots    = 16;
  localparam int unsigned StatEntries = 8;
  localparam int unsigned SlotW       = 4;
  localparam int unsigned DiagW       = 3;
  localparam int unsigned CountW      = 5;
  localparam int unsigned QDepth      = 2;
  localparam logic [31:0] PeriodReset = 32'd1000000;
  localparam logic [CountW-1:0] CountReset = CountW'(1);

  typedef enum logic [2:0] {
    MODE_TICK  = 3'd0,
    MODE_DONE  = 3'd1,
    MODE_WRITE = 3'd2,
    MODE_CLEAR = 3'd3,
    MODE_READ  = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_DONE  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_SLOT_COUNT = 2'd0,
    REG_PERIOD     = 2'd1
  } reg_e;

  typedef struct packed {
    logic [2:0]       mode;
    logic [31:0]      time_us;
    logic [SlotW-1:0] slot_index;
    logic [31:0]      slot_duration_us;
    logic [DiagW-1:0] diag_index;
  } in_item_t;

  typedef struct packed {
    logic             fired;
    logic [SlotW-1:0] fired_slot;
    logic [DiagW-1:0] fired_diag;
    logic             snapshot_taken;
    logic [31:0]      max_time_us;
    logic [31:0]      max_time_all_us;
    logic [31:0]      run_count;
    logic [31:0]      rate_per_period;
  } out_item_t;

  // classified command passed from front to back
  typedef struct packed {
    logic             valid_op;
    op_e              op;
    logic [31:0]      time_us;
    logic [DiagW-1:0] diag;
    logic             diag_ok;
    logic [31:0]      slot_len;
    logic [DiagW-1:0] slot_diag;
    logic [SlotW-1:0] slot;
    logic             fire;
    logic             snap;
  } cmd_t;

endpackage

[rtl/core/tscs_front.sv]
// ----------------------------------------------------------------------------
// tscs_front
// Accepts items, holds the slot table and tick sequencing, emits commands.
// ----------------------------------------------------------------------------
module tscs_front
  import tscs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_data_i,
  input  logic [CountW-1:0] slot_count_i,
  input  logic [31:0]       period_i,
  output logic              cmd_valid_o,
  input  logic              cmd_stall_i,
  output cmd_t              cmd_o
);

  logic [31:0]      len_mem [MaxSlots];
  logic [DiagW-1:0] diag_mem [MaxSlots];

  logic             first_q, first_d;
  logic [SlotW-1:0] next_q, next_d;
  logic [31:0]      plen_q, plen_d;
  logic [31:0]      ptime_q, ptime_d;
  logic [31:0]      pstart_q, pstart_d;

  // phase 0: accept, phase 1: table read done, emit
  logic     busy_q;
  in_item_t item_q;
  logic [SlotW-1:0] rd_slot_q;
  logic [31:0]      rd_len_q;
  logic [DiagW-1:0] rd_diag_q;
  logic             fire_q;
  logic [CountW-1:0] cnt;
  logic [SlotW-1:0] slot_sel;
  logic             acc;
  logic             fire_now;
  logic [CountW-1:0] nxt_w;
  logic             wrap;

  assign in_stall_o = busy_q;
  assign acc = in_valid_i && !busy_q;

  always_comb begin
    if (slot_count_i == '0) begin
      cnt = CountW'(1);
    end else if (slot_count_i > CountW'(MaxSlots)) begin
      cnt = CountW'(MaxSlots);
    end else begin
      cnt = slot_count_i;
    end
  end

  always_comb begin
    fire_now = first_q || ((in_data_i.time_us - ptime_q) >= plen_q);
    if (first_q) begin
      slot_sel = '0;
    end else if ({1'b0, next_q} < cnt) begin
      slot_sel = next_q;
    end else begin
      slot_sel = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && in_data_i.mode == MODE_WRITE) begin
      len_mem[in_data_i.slot_index]  <= in_data_i.slot_duration_us;
      diag_mem[in_data_i.slot_index] <= in_data_i.diag_index;
    end
    if (acc) begin
      item_q    <= in_data_i;
      rd_slot_q <= slot_sel;
      rd_len_q  <= len_mem[slot_sel];
      rd_diag_q <= diag_mem[slot_sel];
      fire_q    <= fire_now;
    end
  end

  assign nxt_w = {1'b0, rd_slot_q} + CountW'(1);
  assign wrap  = nxt_w >= cnt;

  always_comb begin
    first_d  = first_q;
    next_d   = next_q;
    plen_d   = plen_q;
    ptime_d  = ptime_q;
    pstart_d = pstart_q;
    cmd_o    = '0;
    cmd_o.time_us   = item_q.time_us;
    cmd_o.diag      = item_q.diag_index;
    cmd_o.diag_ok   = 32'(item_q.diag_index) < StatEntries;
    cmd_o.slot_len  = rd_len_q;
    cmd_o.slot_diag = rd_diag_q;
    cmd_o.slot      = rd_slot_q;
    cmd_o.valid_op  = 1'b1;
    unique case (item_q.mode)
      MODE_TICK: begin
        cmd_o.op = OP_TICK;
        if (fire_q) begin
          cmd_o.fire = 1'b1;
          if (first_q) begin
            first_d = 1'b0;
          end
          next_d = wrap ? '0 : nxt_w[SlotW-1:0];
          if (wrap && (item_q.time_us -
              (first_q ? item_q.time_us : pstart_q)) >= period_i) begin
            cmd_o.snap = 1'b1;
            pstart_d = item_q.time_us;
          end else if (first_q) begin
            pstart_d = item_q.time_us;
          end
          ptime_d = item_q.time_us;
          plen_d  = rd_len_q;
        end
      end
      MODE_DONE:  cmd_o.op = OP_DONE;
      MODE_CLEAR: cmd_o.op = OP_CLEAR;
      MODE_READ:  cmd_o.op = OP_READ;
      default:    cmd_o.valid_op = 1'b0;
    endcase
  end

  assign cmd_valid_o = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      first_q  <= 1'b1;
      next_q   <= '0;
      plen_q   <= '0;
      ptime_q  <= '0;
      pstart_q <= '0;
    end else begin
      if (acc) begin
        busy_q <= 1'b1;
      end else if (busy_q && !cmd_stall_i) begin
        busy_q   <= 1'b0;
        first_q  <= first_d;
        next_q   <= next_d;
        plen_q   <= plen_d;
        ptime_q  <= ptime_d;
        pstart_q <= pstart_d;
      end
    end
  end

endmodule

[rtl/core/tscs_queue.sv]
// ----------------------------------------------------------------------------
// tscs_queue
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module tscs_queue
  import tscs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_stall_o,
  input  cmd_t wr_data_i,
  output logic rd_valid_o,
  input  logic rd_stall_i,
  output cmd_t rd_data_o
);

  cmd_t       mem_q [QDepth];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign wr_stall_o = cnt_q == 2'(QDepth);
  assign rd_valid_o = cnt_q != '0;
  assign rd_data_o  = mem_q[rp_q];
  assign push = wr_valid_i && !wr_stall_o;
  assign pop  = rd_valid_o && !rd_stall_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

[rtl/core/tscs_back.sv]
// ----------------------------------------------------------------------------
// tscs_back
// Executes commands on the statistics and registers one result.
// ----------------------------------------------------------------------------
module tscs_back
  import tscs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  output logic      cmd_stall_o,
  input  cmd_t      cmd_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic [31:0] max_q  [StatEntries];
  logic [31:0] maxa_q [StatEntries];
  logic [31:0] run_q  [StatEntries];
  logic [31:0] rate_q [StatEntries];
  logic             await_q;
  logic [DiagW-1:0] rdiag_q;
  logic [31:0]      start_q;
  logic             ovalid_q;
  out_item_t        odata_q;
  out_item_t        res;
  logic             take;
  logic [31:0]      dt;

  assign cmd_stall_o = ovalid_q && out_stall_i;
  assign take = cmd_valid_i && !cmd_stall_o;
  assign dt = cmd_i.time_us - start_q;
  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

  always_comb begin
    res = '0;
    if (cmd_i.valid_op && cmd_i.op == OP_TICK && cmd_i.fire) begin
      res.fired          = 1'b1;
      res.fired_slot     = cmd_i.slot;
      res.fired_diag     = cmd_i.slot_diag;
      res.snapshot_taken = cmd_i.snap;
    end
    if (cmd_i.valid_op && cmd_i.op == OP_READ && cmd_i.diag_ok) begin
      res.max_time_us     = max_q[cmd_i.diag];
      res.max_time_all_us = maxa_q[cmd_i.diag];
      res.run_count       = run_q[cmd_i.diag];
      res.rate_per_period = rate_q[cmd_i.diag];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
      odata_q  <= '0;
      await_q  <= 1'b0;
      rdiag_q  <= '0;
      start_q  <= '0;
      for (int i = 0; i < StatEntries; i++) begin
        max_q[i]  <= '0;
        maxa_q[i] <= '0;
        run_q[i]  <= '0;
        rate_q[i] <= '0;
      end
    end else begin
      if (out_valid_o && !out_stall_i) ovalid_q <= 1'b0;
      if (take) begin
        ovalid_q <= 1'b1;
        odata_q  <= res;
        if (cmd_i.valid_op) begin
          unique case (cmd_i.op)
            OP_TICK: begin
              if (cmd_i.fire) begin
                await_q <= 1'b1;
                rdiag_q <= cmd_i.slot_diag;
                start_q <= cmd_i.time_us;
                for (int i = 0; i < StatEntries; i++) begin
                  if (cmd_i.snap) begin
                    rate_q[i] <= (DiagW'(i) == cmd_i.slot_diag && run_q[i] != '1)
                                 ? run_q[i] + 32'd1 : run_q[i];
                    run_q[i]  <= '0;
                  end else if (DiagW'(i) == cmd_i.slot_diag && run_q[i] != '1) begin
                    run_q[i] <= run_q[i] + 32'd1;
                  end
                end
              end
            end
            OP_DONE: begin
              if (await_q) begin
                await_q <= 1'b0;
                if (dt > max_q[rdiag_q])  max_q[rdiag_q]  <= dt;
                if (dt > maxa_q[rdiag_q]) maxa_q[rdiag_q] <= dt;
              end
            end
            OP_CLEAR: begin
              for (int i = 0; i < StatEntries; i++) max_q[i] <= '0;
            end
            OP_READ: ;
            default: ;
          endcase
        end
      end
    end
  end

endmodule

[rtl/core/time_slot_cyclic_scheduler_top.sv]
// ----------------------------------------------------------------------------
// time_slot_cyclic_scheduler_top
// Table-driven cyclic slot scheduler with run statistics.
// ----------------------------------------------------------------------------
// Usage: items enter on in_valid_i/in_stall_o/in_data_i; one result per item
// leaves on out_valid_o/out_stall_i/out_data_o. Registers slot_count (0x0)
// and snapshot_period_us (0x4) are written over the APB port; the user must
// write them only while idle, which the block does not enforce. The front
// reads the slot table as it takes an item and hands a command to a two-entry
// queue; the back updates statistics and registers the result. The front
// takes no new item before its command is handed to the queue. Reset clears
// the sequencing state and all statistics; slot table entries are undefined
// until written. When the receiver stalls, the held result backs up into the
// queue and then the front, which then stalls its input.
// ----------------------------------------------------------------------------
module time_slot_cyclic_scheduler_top
  import tscs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [CountW-1:0] count_q;
  logic [31:0]       period_q;
  logic  f_valid, f_stall, b_valid, b_stall;
  cmd_t  f_cmd, b_cmd;
  reg_e  ra;

  assign pready = 1'b1;
  assign ra = reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= CountReset;
      period_q <= PeriodReset;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      unique case (ra)
        REG_SLOT_COUNT: count_q  <= pwdata[CountW-1:0];
        REG_PERIOD:     period_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ra)
      REG_SLOT_COUNT: prdata = 32'(count_q);
      REG_PERIOD:     prdata = period_q;
      default:        prdata = '0;
    endcase
  end

  tscs_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .slot_count_i(count_q), .period_i(period_q),
    .cmd_valid_o(f_valid), .cmd_stall_i(f_stall), .cmd_o(f_cmd)
  );

  tscs_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i(f_valid), .wr_stall_o(f_stall), .wr_data_i(f_cmd),
    .rd_valid_o(b_valid), .rd_stall_i(b_stall), .rd_data_o(b_cmd)
  );

  tscs_back u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(b_valid), .cmd_stall_o(b_stall), .cmd_i(b_cmd),
    .out_valid_o, .out_stall_i, .out_data_o
  );

endmodule

[rtl/core/tscs_checker.sv]
// ----------------------------------------------------------------------------
// tscs_checker
// Port-level checks of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module tscs_checker
  import tscs_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  a_snap_fired: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.snapshot_taken |-> out_data_o.fired)
    else $error("snapshot without fire");

  a_fire_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.fired |-> out_data_o.run_count == '0)
    else $error("fire result carries read data");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_take_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("front took two items back to back");

endmodule

bind time_slot_cyclic_scheduler_top tscs_checker u_tscs_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .out_data_o
);
